/* design/nvr_pkg.sv */
// Package for the normal vector to RGBA encoder: defaults, register indexes, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nvr_pkg;
  localparam int GRAD_WIDTH_DEF  = 16;
  localparam int COORD_WIDTH_DEF = 12;
  localparam int CHAN_BITS       = 8;
  localparam int DIV_STAGES      = CHAN_BITS;
  localparam logic [CHAN_BITS-1:0] ALPHA_BYTE    = 8'hFF;
  localparam logic [CHAN_BITS-1:0] CHAN_ZERO_LEN = 8'd127;
  localparam logic [CHAN_BITS-1:0] CHAN_MIN      = 8'd0;
  localparam logic [CHAN_BITS:0]   CHAN_SCALE    = 9'd255;

  typedef enum logic [0:0] {
    REG_TILE_X = 1'b0,
    REG_TILE_Y = 1'b1
  } cfg_reg_e;
endpackage
`default_nettype wire

/* design/nvr_if.sv */
// Request channel interfaces of the encoder: input gradients and output pixels.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface nvr_in_if #(
  parameter int GW = 16,
  parameter int CW = 12
);
  logic                 valid;
  logic                 ready;
  logic [CW-1:0]        offset_x;
  logic [CW-1:0]        offset_y;
  logic signed [GW-1:0] grad_x;
  logic signed [GW-1:0] grad_y;
  logic signed [GW-1:0] grad_z;
  modport source (output valid, offset_x, offset_y, grad_x, grad_y, grad_z, input ready);
  modport sink   (input valid, offset_x, offset_y, grad_x, grad_y, grad_z, output ready);
endinterface

interface nvr_out_if #(
  parameter int CW = 12
);
  logic          valid;
  logic          ready;
  logic [CW:0]   pixel_x;
  logic [CW:0]   pixel_y;
  logic [31:0]   packed_normal;
  modport source (output valid, pixel_x, pixel_y, packed_normal, input ready);
  modport sink   (input valid, pixel_x, pixel_y, packed_normal, output ready);
endinterface
`default_nettype wire

/* design/nvr_sqsum.sv */
// Squares of the three gradient magnitudes, then their sum (two stages).
// Depends on nothing but its ports.
`timescale 1ns / 1ps
`default_nettype none
module nvr_sqsum #(
  parameter int GW = 16
) (
  input  wire logic                 clk_i,
  input  wire logic [1:0]           adv_i,
  input  wire logic signed [GW-1:0] gx_i,
  input  wire logic signed [GW-1:0] gy_i,
  input  wire logic signed [GW-1:0] gz_i,
  output logic [2*GW-1:0]           sum_o
);
  localparam int SW = 2 * GW;

  logic [GW-1:0] mx, my, mz;
  logic [SW-1:0] sqx_q, sqy_q, sqz_q;
  logic [SW-1:0] sum_d, sum_q;
  logic [SW+1:0] wide_sum;

  // magnitude of the most negative value still fits unsigned
  assign mx = gx_i[GW-1] ? GW'(~$unsigned(gx_i) + 1'b1) : $unsigned(gx_i);
  assign my = gy_i[GW-1] ? GW'(~$unsigned(gy_i) + 1'b1) : $unsigned(gy_i);
  assign mz = gz_i[GW-1] ? GW'(~$unsigned(gz_i) + 1'b1) : $unsigned(gz_i);

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      sqx_q <= mx * mx;
      sqy_q <= my * my;
      sqz_q <= mz * mz;
    end
  end

  // three squares stay below 2^(2*GW)
  assign wide_sum = {2'b0, sqx_q} + {2'b0, sqy_q} + {2'b0, sqz_q};
  assign sum_d    = wide_sum[SW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv_i[1]) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;
endmodule
`default_nettype wire

/* design/nvr_isqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on nothing but its ports.
`timescale 1ns / 1ps
`default_nettype none
module nvr_isqrt #(
  parameter int GW = 16
) (
  input  wire logic            clk_i,
  input  wire logic [GW-1:0]   adv_i,
  input  wire logic [2*GW-1:0] sum_i,
  output logic [GW-1:0]        root_o
);
  localparam int SW = 2 * GW;

  logic [SW-1:0] rem_q  [GW];
  logic [SW-1:0] root_q [GW];

  for (genvar j = 0; j < GW; j++) begin : g_stage
    localparam logic [SW-1:0] BIT = SW'(1) << (2 * (GW - 1 - j));
    logic [SW-1:0] rem_in, root_in, trial, rem_d, root_d;

    if (j == 0) begin : g_first
      assign rem_in  = sum_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign trial = root_in + BIT;

    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + BIT;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[j]) begin
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
      end
    end
  end

  assign root_o = root_q[GW-1][GW-1:0];
endmodule
`default_nettype wire

/* design/nvr_chan.sv */
// One color channel: offset by the length, scale by 255, divide by twice the length.
// Depends on nvr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nvr_chan #(
  parameter int GW = 16
) (
  input  wire logic                          clk_i,
  input  wire logic [nvr_pkg::DIV_STAGES:0]  adv_i,
  input  wire logic signed [GW-1:0]          d_i,
  input  wire logic [GW-1:0]                 len_i,
  output logic [nvr_pkg::CHAN_BITS-1:0]      chan_o
);
  import nvr_pkg::*;

  localparam int NW = GW + 9;

  logic [NW-1:0]        rem_q [DIV_STAGES+1];
  logic [GW:0]          den_q [DIV_STAGES+1];
  logic [CHAN_BITS-1:0] quo_q [DIV_STAGES+1];
  logic                 zl_q  [DIV_STAGES+1];
  logic                 np_q  [DIV_STAGES+1];

  logic signed [GW+1:0] s;
  logic [GW:0]          s_u;
  logic [NW-1:0]        num;

  assign s   = $signed({{2{d_i[GW-1]}}, d_i}) + $signed({2'b00, len_i});
  assign s_u = s[GW:0];
  assign num = {s_u, 8'b0} - NW'(s_u);

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      rem_q[0] <= num;
      den_q[0] <= {len_i, 1'b0};
      quo_q[0] <= '0;
      zl_q[0]  <= (len_i == '0);
      np_q[0]  <= s[GW+1] || (s == '0);
    end
  end

  // restoring division, quotient known to stay below 256
  for (genvar i = 1; i <= DIV_STAGES; i++) begin : g_div
    localparam int B = DIV_STAGES - i;
    logic [NW-1:0]        trial, rem_d;
    logic [CHAN_BITS-1:0] quo_d, quo_out;

    assign trial = NW'(den_q[i-1]) << B;

    always_comb begin
      quo_d = quo_q[i-1];
      if (rem_q[i-1] >= trial) begin
        rem_d    = rem_q[i-1] - trial;
        quo_d[B] = 1'b1;
      end else begin
        rem_d = rem_q[i-1];
      end
    end

    if (i == DIV_STAGES) begin : g_last
      assign quo_out = zl_q[i-1] ? CHAN_ZERO_LEN : (np_q[i-1] ? CHAN_MIN : quo_d);
    end else begin : g_mid
      assign quo_out = quo_d;
    end

    always_ff @(posedge clk_i) begin
      if (adv_i[i]) begin
        rem_q[i] <= rem_d;
        den_q[i] <= den_q[i-1];
        quo_q[i] <= quo_out;
        zl_q[i]  <= zl_q[i-1];
        np_q[i]  <= np_q[i-1];
      end
    end
  end

  assign chan_o = quo_q[DIV_STAGES];
endmodule
`default_nettype wire

/* design/normal_vector_to_rgba.sv */
// Top level of the normal vector to RGBA encoder.
// Depends on nvr_pkg, nvr_if, nvr_sqsum, nvr_isqrt, nvr_chan.
`timescale 1ns / 1ps
`default_nettype none
// Encodes a surface gradient as an 8-bit normal-map pixel. Length L = floor(sqrt(gx^2+gy^2+gz^2)),
// each channel floor(255*(d+L)/(2L)), 127 on every channel for a zero gradient, packed as
// FF|Z|Y|X. Pixel address = tile origin register + offset, computed at request accept with the
// origin registers as they stand. Throughput: one request per cycle unless every stage is full
// and the output is not ready. The stages are the squares and sum, the square root at one root
// bit per stage, the channel setup, and the quotient at one bit per stage. Every stage carries
// its own valid bit and stalls only when it holds data the next stage cannot take, so bubbles
// are squeezed out and requests keep entering while a result waits at the output.
module normal_vector_to_rgba
  import nvr_pkg::*;
#(
  parameter int GRAD_WIDTH  = GRAD_WIDTH_DEF,
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire nvr_pkg::cfg_reg_e       cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0]  cfg_data_i,
  nvr_in_if.sink                       in_req,
  nvr_out_if.source                    out_req
);
  localparam int GW = GRAD_WIDTH;
  localparam int CW = COORD_WIDTH;
  localparam int SQ_FIRST = 2;             // first square root stage
  localparam int CH_FIRST = SQ_FIRST + GW; // channel setup stage
  localparam int NS = CH_FIRST + DIV_STAGES + 1;

  // config registers
  logic [CW-1:0] tile_x_q, tile_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_x_q <= '0;
      tile_y_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TILE_X: tile_x_q <= cfg_data_i;
        REG_TILE_Y: tile_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid bits and per-stage advance
  logic [NS-1:0] v_q, v_d;
  logic [NS:0]   rdy;
  logic [NS-1:0] adv;

  always_comb begin
    rdy[NS] = out_req.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign adv          = rdy[NS-1:0];
  assign in_req.ready = rdy[0];

  always_comb begin
    v_d[0] = adv[0] ? in_req.valid : v_q[0];
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        v_d[k] = v_q[k-1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // pixel address travels alongside the whole pipe
  logic [CW:0] px_q [NS];
  logic [CW:0] py_q [NS];

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      px_q[0] <= {1'b0, tile_x_q} + {1'b0, in_req.offset_x};
      py_q[0] <= {1'b0, tile_y_q} + {1'b0, in_req.offset_y};
    end
    for (int k = 1; k < NS; k++) begin
      if (adv[k]) begin
        px_q[k] <= px_q[k-1];
        py_q[k] <= py_q[k-1];
      end
    end
  end

  // gradients wait until the channel setup stage
  logic signed [GW-1:0] gx_q [CH_FIRST];
  logic signed [GW-1:0] gy_q [CH_FIRST];
  logic signed [GW-1:0] gz_q [CH_FIRST];

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      gx_q[0] <= in_req.grad_x;
      gy_q[0] <= in_req.grad_y;
      gz_q[0] <= in_req.grad_z;
    end
    for (int k = 1; k < CH_FIRST; k++) begin
      if (adv[k]) begin
        gx_q[k] <= gx_q[k-1];
        gy_q[k] <= gy_q[k-1];
        gz_q[k] <= gz_q[k-1];
      end
    end
  end

  logic [2*GW-1:0]      sum;
  logic [GW-1:0]        root;
  logic [CHAN_BITS-1:0] cx, cy, cz;

  nvr_sqsum #(.GW(GW)) u_sqsum (
    .clk_i (clk_i),
    .adv_i (adv[1:0]),
    .gx_i  (in_req.grad_x),
    .gy_i  (in_req.grad_y),
    .gz_i  (in_req.grad_z),
    .sum_o (sum)
  );

  nvr_isqrt #(.GW(GW)) u_isqrt (
    .clk_i  (clk_i),
    .adv_i  (adv[CH_FIRST-1:SQ_FIRST]),
    .sum_i  (sum),
    .root_o (root)
  );

  nvr_chan #(.GW(GW)) u_chan_x (
    .clk_i  (clk_i),
    .adv_i  (adv[NS-1:CH_FIRST]),
    .d_i    (gx_q[CH_FIRST-1]),
    .len_i  (root),
    .chan_o (cx)
  );

  nvr_chan #(.GW(GW)) u_chan_y (
    .clk_i  (clk_i),
    .adv_i  (adv[NS-1:CH_FIRST]),
    .d_i    (gy_q[CH_FIRST-1]),
    .len_i  (root),
    .chan_o (cy)
  );

  nvr_chan #(.GW(GW)) u_chan_z (
    .clk_i  (clk_i),
    .adv_i  (adv[NS-1:CH_FIRST]),
    .d_i    (gz_q[CH_FIRST-1]),
    .len_i  (root),
    .chan_o (cz)
  );

  // last stage is the output register
  assign out_req.valid         = v_q[NS-1];
  assign out_req.pixel_x       = px_q[NS-1];
  assign out_req.pixel_y       = py_q[NS-1];
  assign out_req.packed_normal = {ALPHA_BYTE, cz, cy, cx};

  // accepted request lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req.valid && in_req.ready |=> v_q[0])
    else $error("accepted request missing from first stage");

  // input only stalls when every stage holds data
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_req.ready |-> (&v_q) && !out_req.ready)
    else $error("input stalled with a free stage");

  // a valid first stage hands its data on when the second stage advances
  a_stage_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && adv[1] |=> v_q[1])
    else $error("request lost between first and second stage");
endmodule
`default_nettype wire
